[src/hvn_pkg.sv]
// Shared constants, types and register codes for the heightfield vertex normal unit.
`timescale 1ns / 1ps
package hvn_pkg;

  localparam int MAX_VERTICES_PER_ROW = 64;
  localparam int COL_W = $clog2(MAX_VERTICES_PER_ROW);
  localparam int VPR_W = $clog2(MAX_VERTICES_PER_ROW + 1);
  localparam int HEIGHT_W = 16;
  localparam int STEP_W = 16;
  localparam int DIFF_W = HEIGHT_W + 1;
  localparam int NORMAL_W = 2 * STEP_W + 2;
  localparam int CFG_DATA_W = (VPR_W > STEP_W) ? VPR_W : STEP_W;
  localparam int CFG_IDX_W = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [VPR_W-1:0] VPR_MIN = VPR_W'(4);
  localparam logic [VPR_W-1:0] VPR_MAX = VPR_W'(MAX_VERTICES_PER_ROW);
  localparam logic [VPR_W-1:0] VPR_RESET = VPR_W'(MAX_VERTICES_PER_ROW);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTICES_PER_ROW = 1'b0,
    REG_GRID_STEP        = 1'b1
  } hvn_reg_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height;
    logic [COL_W-1:0]           row_out;
    logic [COL_W-1:0]           col;
    logic                       emit;
    logic                       done;
  } hvn_item_t;

endpackage

[src/heightfield_vertex_normals_unit.sv]
// Top level of the heightfield vertex normal unit: configuration registers and wiring.
//
//   Channel   Direction  Handshake            Payload
//   in        sink       in_valid/in_ready    height, frame_start
//   out       source     out_valid/out_ready  normal_x/y/z, vertex_row, vertex_col, grid_done
//   cfg       sink       cfg_we               cfg_index, cfg_data
//
// One height request is taken per cycle while the queue has room; normals are registered.
// The rate is set by the three row-store memories, each read once and written once a cycle.
// Reset clears the grid position, the request queue and all valid flags.
// A stalled output holds the whole back end; the four-entry queue then takes up to four
// more requests before in_ready falls.
`timescale 1ns / 1ps
module heightfield_vertex_normals_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [hvn_pkg::HEIGHT_W-1:0]  height,
  input  logic                                 frame_start,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [hvn_pkg::NORMAL_W-1:0]  normal_x,
  output logic [hvn_pkg::NORMAL_W-1:0]         normal_y,
  output logic signed [hvn_pkg::NORMAL_W-1:0]  normal_z,
  output logic [hvn_pkg::COL_W-1:0]            vertex_row,
  output logic [hvn_pkg::COL_W-1:0]            vertex_col,
  output logic                                 grid_done,
  input  logic                                 cfg_we,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hvn_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import hvn_pkg::*;

  logic [VPR_W-1:0]  vertices_per_row;
  logic [STEP_W-1:0] grid_step;
  logic              push;
  hvn_item_t         push_item;
  logic              queue_full;
  logic              pop;
  logic              nonempty;
  hvn_item_t         head;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertices_per_row <= VPR_RESET;
      grid_step <= STEP_RESET;
    end else if (cfg_we) begin
      case (hvn_reg_t'(cfg_index))
        REG_VERTICES_PER_ROW: vertices_per_row <= cfg_data[VPR_W-1:0];
        REG_GRID_STEP:        grid_step <= cfg_data[STEP_W-1:0];
        default:              grid_step <= grid_step;
      endcase
    end
  end

  hvn_front u_front (
    .clk              (clk),
    .rst              (rst),
    .vertices_per_row (vertices_per_row),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .height           (height),
    .frame_start      (frame_start),
    .queue_full       (queue_full),
    .push             (push),
    .push_item        (push_item)
  );

  hvn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head)
  );

  hvn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .grid_step  (grid_step),
    .nonempty   (nonempty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .vertex_row (vertex_row),
    .vertex_col (vertex_col),
    .grid_done  (grid_done)
  );

endmodule

[src/hvn_ram.sv]
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module hvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/hvn_front.sv]
// Front end: accepts heights, tracks grid position and classifies interior vertices.
`timescale 1ns / 1ps
module hvn_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [hvn_pkg::VPR_W-1:0]            vertices_per_row,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [hvn_pkg::HEIGHT_W-1:0]  height,
  input  logic                                 frame_start,
  input  logic                                 queue_full,
  output logic                                 push,
  output hvn_pkg::hvn_item_t                   push_item
);
  import hvn_pkg::*;

  logic [COL_W-1:0] row_count, row_count_next;
  logic [COL_W-1:0] col_count, col_count_next;
  logic [VPR_W-1:0] n;
  logic [VPR_W-1:0] r_ext, c_ext;
  logic [COL_W-1:0] r, c;

  always_comb begin
    if (vertices_per_row < VPR_MIN) begin
      n = VPR_MIN;
    end else if (vertices_per_row > VPR_MAX) begin
      n = VPR_MAX;
    end else begin
      n = vertices_per_row;
    end
  end

  assign r = frame_start ? '0 : row_count;
  assign c = frame_start ? '0 : col_count;
  assign r_ext = VPR_W'(r);
  assign c_ext = VPR_W'(c);

  assign in_ready = !queue_full;
  assign push = in_valid && in_ready;

  always_comb begin
    push_item.height = height;
    push_item.row_out = r - COL_W'(1);
    push_item.col = c;
    push_item.emit = (r_ext >= VPR_W'(2)) && (r_ext <= n - VPR_W'(1)) &&
                     (c_ext >= VPR_W'(1)) && (c_ext <= n - VPR_W'(2));
    push_item.done = (r_ext == n - VPR_W'(1)) && (c_ext == n - VPR_W'(2));
  end

  always_comb begin
    if (c_ext + VPR_W'(1) >= n) begin
      col_count_next = '0;
      row_count_next = (r_ext + VPR_W'(1) >= n) ? '0 : r + COL_W'(1);
    end else begin
      col_count_next = c + COL_W'(1);
      row_count_next = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (push) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

endmodule

[src/hvn_queue.sv]
// Short request queue between the front end and the stencil back end.
`timescale 1ns / 1ps
module hvn_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hvn_pkg::hvn_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               nonempty,
  output hvn_pkg::hvn_item_t head
);
  import hvn_pkg::*;

  hvn_item_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[src/hvn_back.sv]
// Back end: row stores with forwarding, height differences and normal products.
`timescale 1ns / 1ps
module hvn_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [hvn_pkg::STEP_W-1:0]           grid_step,
  input  logic                                 nonempty,
  input  hvn_pkg::hvn_item_t                   head,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [hvn_pkg::NORMAL_W-1:0]  normal_x,
  output logic [hvn_pkg::NORMAL_W-1:0]         normal_y,
  output logic signed [hvn_pkg::NORMAL_W-1:0]  normal_z,
  output logic [hvn_pkg::COL_W-1:0]            vertex_row,
  output logic [hvn_pkg::COL_W-1:0]            vertex_col,
  output logic                                 grid_done
);
  import hvn_pkg::*;

  logic advance;

  logic                       a_valid;
  hvn_item_t                  a_item;
  logic                       fwd_center;
  logic                       fwd_right;
  logic signed [HEIGHT_W-1:0] fwd_height;
  logic signed [HEIGHT_W-1:0] fwd_above;

  logic [HEIGHT_W-1:0]        above_rd, center_rd, right_rd;
  logic signed [HEIGHT_W-1:0] above_eff, center_eff, right_eff;
  logic signed [HEIGHT_W-1:0] left_hold;
  logic                       a_write;

  logic                       b_valid;
  logic signed [DIFF_W-1:0]   b_dx;
  logic signed [DIFF_W-1:0]   b_dz;
  logic [COL_W-1:0]           b_row;
  logic [COL_W-1:0]           b_col;
  logic                       b_done;

  logic signed [DIFF_W-1:0]     step_s;
  logic signed [2*DIFF_W-1:0]   prod_x, prod_z;
  logic [2*STEP_W-1:0]          prod_y;
  logic [COL_W-1:0]             head_right;

  assign advance = !out_valid || out_ready;
  assign pop = advance && nonempty;
  assign a_write = advance && a_valid;
  assign head_right = head.col + COL_W'(1);

  assign above_eff = fwd_center ? fwd_above : $signed(above_rd);
  assign center_eff = fwd_center ? fwd_height : $signed(center_rd);
  assign right_eff = fwd_right ? fwd_height : $signed(right_rd);

  hvn_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_VERTICES_PER_ROW)) u_above_ram (
    .clk   (clk),
    .we    (a_write),
    .waddr (a_item.col),
    .wdata (center_eff),
    .re    (pop),
    .raddr (head.col),
    .rdata (above_rd)
  );

  hvn_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_VERTICES_PER_ROW)) u_center_ram (
    .clk   (clk),
    .we    (a_write),
    .waddr (a_item.col),
    .wdata (a_item.height),
    .re    (pop),
    .raddr (head.col),
    .rdata (center_rd)
  );

  hvn_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_VERTICES_PER_ROW)) u_right_ram (
    .clk   (clk),
    .we    (a_write),
    .waddr (a_item.col),
    .wdata (a_item.height),
    .re    (pop),
    .raddr (head_right),
    .rdata (right_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      left_hold <= '0;
    end else if (advance) begin
      a_valid <= nonempty;
      if (a_valid) begin
        left_hold <= center_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_item <= head;
      fwd_center <= a_valid && (head.col == a_item.col);
      fwd_right <= a_valid && (head_right == a_item.col);
      fwd_height <= a_item.height;
      fwd_above <= center_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid && a_item.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_dx <= DIFF_W'(left_hold) - DIFF_W'(right_eff);
      b_dz <= DIFF_W'(above_eff) - DIFF_W'(a_item.height);
      b_row <= a_item.row_out;
      b_col <= a_item.col;
      b_done <= a_item.done;
    end
  end

  assign step_s = $signed({1'b0, grid_step});
  assign prod_x = b_dx * step_s;
  assign prod_z = b_dz * step_s;
  assign prod_y = grid_step * grid_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      normal_x <= {prod_x[NORMAL_W-2:0], 1'b0};
      normal_z <= {prod_z[NORMAL_W-2:0], 1'b0};
      normal_y <= {prod_y, 2'b00};
      vertex_row <= b_row;
      vertex_col <= b_col;
      grid_done <= b_done;
    end
  end

endmodule

[src/hvn_checker.sv]
// Port-level checks for the heightfield vertex normal unit, bound to the top level.
`timescale 1ns / 1ps
module hvn_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [hvn_pkg::NORMAL_W-1:0]  normal_x,
  input logic [hvn_pkg::NORMAL_W-1:0]         normal_y,
  input logic signed [hvn_pkg::NORMAL_W-1:0]  normal_z,
  input logic [hvn_pkg::COL_W-1:0]            vertex_row,
  input logic [hvn_pkg::COL_W-1:0]            vertex_col,
  input logic                                 grid_done
);
  import hvn_pkg::*;

  // A stalled result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y) &&
      $stable(normal_z) && $stable(vertex_row) && $stable(vertex_col) && $stable(grid_done))
    else $error("output request changed while stalled");

  // Reset leaves no result pending and the input side open.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("unit not idle after reset");

  // Every component carries the factor two or four from the stencil sum.
  a_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x[0] == 1'b0 && normal_z[0] == 1'b0 && normal_y[1:0] == 2'b00)
    else $error("normal component lost its scale factor");

  // The last interior vertex sits on the diagonal, at row and column n minus two.
  a_done_diag: assert property (@(posedge clk) disable iff (rst)
    out_valid && grid_done |-> vertex_row == vertex_col)
    else $error("grid done flagged off the last interior vertex");

endmodule

bind heightfield_vertex_normals_unit hvn_checker u_hvn_checker (.*);
